// File: hdl/scy_pkg.sv
package scy_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned PORT_W = 16;

   localparam int unsigned BUCKET_SHIFT_DEF = 5;
   localparam int unsigned FINAL_SHIFT = 15;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [PORT_W-1:0] port_type;

   localparam word_type K_ROUND1 = 32'h9E3779B1;
   localparam word_type K_ROUND2 = 32'h85EBCA77;
   localparam word_type K_ROUND3 = 32'hC2B2AE3D;
   localparam word_type K_ROUND4 = 32'h27D4EB2F;

   localparam logic REQ_GENERATE = 1'b0;
   localparam logic REQ_VALIDATE = 1'b1;

   // Sideband that rides along with the partial hash through the pipeline.
   typedef struct packed {
      logic     kind;
      word_type daddr;
      word_type ports;
      word_type bucket;
      word_type bucket_prev;
      word_type want;
      logic     prev_ok;
   } item_type;

   function automatic word_type final_mix(input word_type h);
      final_mix = h ^ (h >> FINAL_SHIFT);
   endfunction

endpackage

// File: hdl/scy_if.sv
interface scy_req_if;
   import scy_pkg::*;

   logic     valid;
   logic     ready;
   logic     req_type;
   word_type src_addr;
   port_type src_tcp_port;
   word_type dst_addr;
   port_type dst_tcp_port;
   word_type tick_now;
   word_type ack_number;

   modport source (
      output valid, req_type, src_addr, src_tcp_port, dst_addr, dst_tcp_port,
             tick_now, ack_number,
      input  ready
   );
   modport sink (
      input  valid, req_type, src_addr, src_tcp_port, dst_addr, dst_tcp_port,
             tick_now, ack_number,
      output ready
   );
endinterface

interface scy_rsp_if;
   import scy_pkg::*;

   logic     valid;
   logic     ready;
   word_type cookie;
   logic     accepted;

   modport source (output valid, cookie, accepted, input ready);
   modport sink (input valid, cookie, accepted, output ready);
endinterface

interface scy_csr_if;
   import scy_pkg::*;

   logic     valid;
   logic     ready;
   word_type hash_secret;

   modport source (output valid, hash_secret, input ready);
   modport sink (input valid, hash_secret, output ready);
endinterface

// File: hdl/scy_mix_stage.sv
module scy_mix_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  scy_pkg::word_type in_hash,
   input  scy_pkg::word_type in_word,
   input  scy_pkg::word_type k_mult,
   input  scy_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output scy_pkg::word_type out_hash,
   output scy_pkg::item_type out_item
);
   import scy_pkg::*;

   logic     valid_ff;
   word_type hash_ff;
   word_type hash_in;
   item_type item_ff;

   // One xor-multiply round, product kept modulo 2^32.
   assign hash_in  = (in_hash ^ in_word) * k_mult;
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hash_ff <= hash_in;
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_hash  = hash_ff;
   assign out_item  = item_ff;

endmodule

// File: hdl/scy_last_stage.sv
module scy_last_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  scy_pkg::word_type in_hash,
   input  scy_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output scy_pkg::word_type out_hash_now,
   output scy_pkg::word_type out_hash_prev,
   output scy_pkg::item_type out_item
);
   import scy_pkg::*;

   logic     valid_ff;
   word_type now_ff;
   word_type now_in;
   word_type prev_ff;
   word_type prev_in;
   item_type item_ff;

   // The first three rounds are shared; fork here for the two time buckets.
   assign now_in   = (in_hash ^ in_item.bucket) * K_ROUND4;
   assign prev_in  = (in_hash ^ in_item.bucket_prev) * K_ROUND4;
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         now_ff  <= now_in;
         prev_ff <= prev_in;
         item_ff <= in_item;
      end
   end

   assign out_valid     = valid_ff;
   assign out_hash_now  = now_ff;
   assign out_hash_prev = prev_ff;
   assign out_item      = item_ff;

endmodule

// File: hdl/scy_check.sv
module scy_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  scy_pkg::word_type in_hash_now,
   input  scy_pkg::word_type in_hash_prev,
   input  scy_pkg::item_type in_item,
   scy_rsp_if.source         rsp_bus
);
   import scy_pkg::*;

   logic     valid_ff;
   word_type cookie_ff;
   word_type cookie_in;
   word_type prev_cookie;
   logic     accepted_ff;
   logic     accepted_in;
   logic     take;

   assign cookie_in   = final_mix(in_hash_now);
   assign prev_cookie = final_mix(in_hash_prev);
   assign accepted_in = (in_item.kind == REQ_VALIDATE) &&
                        ((in_item.want == cookie_in) ||
                         (in_item.prev_ok && (in_item.want == prev_cookie)));

   assign in_ready = !valid_ff || rsp_bus.ready;
   assign take     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cookie_ff   <= cookie_in;
         accepted_ff <= accepted_in;
      end
   end

   assign rsp_bus.valid    = valid_ff;
   assign rsp_bus.cookie   = cookie_ff;
   assign rsp_bus.accepted = accepted_ff;

   a_generate_rejects: assert property (@(posedge clock) disable iff (reset)
      take && (in_item.kind == REQ_GENERATE) |=> !accepted_ff)
      else $error("generate transaction flagged accepted");

   a_current_match: assert property (@(posedge clock) disable iff (reset)
      take && (in_item.kind == REQ_VALIDATE) && (in_item.want == cookie_in)
      |=> accepted_ff)
      else $error("current bucket match not accepted");

   a_bucket_zero: assert property (@(posedge clock) disable iff (reset)
      take && !in_item.prev_ok && (in_item.want != cookie_in) |=> !accepted_ff)
      else $error("previous bucket tried at bucket zero");

   a_cookie_path: assert property (@(posedge clock) disable iff (reset)
      take |=> (cookie_ff == final_mix($past(in_hash_now))))
      else $error("cookie not taken from current bucket hash");

endmodule

// File: hdl/syn_cookie_generate_validate_unit.sv
// SYN cookie generate/validate unit. Accepts one request transaction per clock
// while rsp_bus is not stalling and returns exactly one response transaction
// per request, in order. A request passes through four register stages, one
// per xor-multiply round of the hash (the last round computes the current and
// previous time bucket side by side), then the output register holding the
// final xor-shift and the ack compare. Backpressure on rsp_bus stalls the
// pipeline stage by stage. The hash secret is written through csr_bus, which is
// always ready; write it only while no request is in flight. The time bucket is
// tick_now shifted right by BUCKET_SHIFT.
module syn_cookie_generate_validate_unit #(
   parameter int unsigned BUCKET_SHIFT = scy_pkg::BUCKET_SHIFT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   scy_req_if.sink    req_bus,
   scy_rsp_if.source  rsp_bus,
   scy_csr_if.sink    csr_bus
);
   import scy_pkg::*;

   word_type secret_ff;
   item_type item_c;
   word_type bucket_c;

   logic     v1, v2, v3, v4;
   logic     r2, r3, r4, r5;
   word_type h1, h2, h3, hn4, hp4;
   item_type i1, i2, i3, i4;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         secret_ff <= '0;
      end else if (csr_bus.valid) begin
         secret_ff <= csr_bus.hash_secret;
      end
   end

   assign bucket_c = req_bus.tick_now >> BUCKET_SHIFT;

   always_comb begin
      item_c.kind        = req_bus.req_type;
      item_c.daddr       = req_bus.dst_addr;
      item_c.ports       = {req_bus.src_tcp_port, req_bus.dst_tcp_port};
      item_c.bucket      = bucket_c;
      item_c.bucket_prev = bucket_c - 32'd1;
      item_c.want        = req_bus.ack_number - 32'd1;
      item_c.prev_ok     = (bucket_c != '0);
   end

   scy_mix_stage u_round1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_hash   (secret_ff),
      .in_word   (req_bus.src_addr),
      .k_mult    (K_ROUND1),
      .in_item   (item_c),
      .out_valid (v1),
      .out_ready (r2),
      .out_hash  (h1),
      .out_item  (i1)
   );

   scy_mix_stage u_round2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1),
      .in_ready  (r2),
      .in_hash   (h1),
      .in_word   (i1.daddr),
      .k_mult    (K_ROUND2),
      .in_item   (i1),
      .out_valid (v2),
      .out_ready (r3),
      .out_hash  (h2),
      .out_item  (i2)
   );

   scy_mix_stage u_round3 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2),
      .in_ready  (r3),
      .in_hash   (h2),
      .in_word   (i2.ports),
      .k_mult    (K_ROUND3),
      .in_item   (i2),
      .out_valid (v3),
      .out_ready (r4),
      .out_hash  (h3),
      .out_item  (i3)
   );

   scy_last_stage u_round4 (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (v3),
      .in_ready      (r4),
      .in_hash       (h3),
      .in_item       (i3),
      .out_valid     (v4),
      .out_ready     (r5),
      .out_hash_now  (hn4),
      .out_hash_prev (hp4),
      .out_item      (i4)
   );

   scy_check u_check (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v4),
      .in_ready     (r5),
      .in_hash_now  (hn4),
      .in_hash_prev (hp4),
      .in_item      (i4),
      .rsp_bus      (rsp_bus)
   );

endmodule

// File: dv/tb_syn_cookie_generate_validate_unit.sv
`timescale 1ns / 1ps

module tb_syn_cookie_generate_validate_unit;
   import scy_pkg::*;

   localparam int unsigned SHIFT = 5;
   localparam word_type MUL1 = 32'h9E3779B1;
   localparam word_type MUL2 = 32'h85EBCA77;
   localparam word_type MUL3 = 32'hC2B2AE3D;
   localparam word_type MUL4 = 32'h27D4EB2F;
   localparam int unsigned MIX_SHIFT = 15;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned HOLD_AFTER = 450;

   typedef struct {
      bit       is_cfg;
      word_type secret;
      bit       no_gap;
      logic     kind;
      word_type saddr;
      port_type sport;
      word_type daddr;
      port_type dport;
      word_type tick;
      word_type ack;
   } syn_req_type;

   typedef struct packed {
      word_type cookie;
      logic     accepted;
   } verdict_type;

   logic clock;
   logic reset;
   logic hold_off;

   scy_req_if req_bus ();
   scy_rsp_if rsp_bus ();
   scy_csr_if csr_bus ();

   syn_req_type pending_reqs[$];
   verdict_type verdicts_due[$];
   syn_req_type cur_req;
   word_type    cur_secret;
   word_type    secret_model;
   word_type    plan_secret;
   bit          req_live;
   bit          csr_live;
   int unsigned gap_left;
   int unsigned req_count;
   int unsigned stall_left;
   int unsigned calm_left;
   int unsigned error_count;

   syn_cookie_generate_validate_unit #(.BUCKET_SHIFT(SHIFT)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic word_type cookie_for(word_type key, syn_req_type r, word_type bucket);
      word_type h;
      h = (key ^ r.saddr) * MUL1;
      h = (h ^ r.daddr) * MUL2;
      h = (h ^ {r.sport, r.dport}) * MUL3;
      h = (h ^ bucket) * MUL4;
      return h ^ (h >> MIX_SHIFT);
   endfunction

   function automatic verdict_type predict_verdict(syn_req_type r, word_type key);
      verdict_type v;
      word_type    bucket;
      word_type    want;
      bucket = r.tick >> SHIFT;
      want = r.ack - 32'd1;
      v.cookie = cookie_for(key, r, bucket);
      v.accepted = 1'b0;
      if (r.kind == REQ_VALIDATE) begin
         if (want == v.cookie)
            v.accepted = 1'b1;
         else if (bucket != 0 && want == cookie_for(key, r, bucket - 32'd1))
            v.accepted = 1'b1;
      end
      return v;
   endfunction

   function automatic syn_req_type syn_req(logic kind, word_type sa, port_type sp, word_type da,
                                           port_type dp, word_type tick, word_type ack);
      syn_req_type r;
      r.is_cfg = 1'b0;
      r.secret = '0;
      r.no_gap = 1'b0;
      r.kind = kind;
      r.saddr = sa;
      r.sport = sp;
      r.daddr = da;
      r.dport = dp;
      r.tick = tick;
      r.ack = ack;
      return r;
   endfunction

   // Set ack to the cookie of a bucket "back" steps behind the current one, plus one.
   function automatic syn_req_type with_ack(syn_req_type r, word_type key, word_type back);
      r.ack = cookie_for(key, r, (r.tick >> SHIFT) - back) + 32'd1;
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_secret(word_type s);
      syn_req_type r;
      r = syn_req(REQ_GENERATE, '0, '0, '0, '0, '0, '0);
      r.is_cfg = 1'b1;
      r.secret = s;
      plan_secret = s;
      pending_reqs.push_back(r);
   endtask

   task automatic push_req(syn_req_type r);
      pending_reqs.push_back(r);
   endtask

   // Request driver: drain the pending queue, writing the secret only when idle
   always @(posedge clock) begin : req_driver
      logic        next_req_valid;
      logic        next_csr_valid;
      syn_req_type head;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
         req_live = 1'b0;
         csr_live = 1'b0;
         gap_left = 0;
         req_count = 0;
         secret_model = '0;
      end else begin
         next_req_valid = req_live;
         next_csr_valid = csr_live;
         if (req_live && req_bus.ready) begin
            verdicts_due.push_back(predict_verdict(cur_req, secret_model));
            req_count++;
            req_live = 1'b0;
            next_req_valid = 1'b0;
            if (!cur_req.no_gap && $urandom_range(0, 99) < 40)
               gap_left = pick_gap();
         end
         if (csr_live && csr_bus.ready) begin
            secret_model = cur_secret;
            csr_live = 1'b0;
            next_csr_valid = 1'b0;
         end
         if (!req_live && !csr_live && pending_reqs.size() != 0) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_reqs[0].is_cfg) begin
               // hold the write until every transaction in flight has returned
               if (verdicts_due.size() == 0) begin
                  head = pending_reqs.pop_front();
                  cur_secret = head.secret;
                  csr_bus.hash_secret <= head.secret;
                  csr_live = 1'b1;
                  next_csr_valid = 1'b1;
               end
            end else begin
               head = pending_reqs.pop_front();
               cur_req = head;
               req_bus.req_type <= head.kind;
               req_bus.src_addr <= head.saddr;
               req_bus.src_tcp_port <= head.sport;
               req_bus.dst_addr <= head.daddr;
               req_bus.dst_tcp_port <= head.dport;
               req_bus.tick_now <= head.tick;
               req_bus.ack_number <= head.ack;
               req_live = 1'b1;
               next_req_valid = 1'b1;
            end
         end
         req_bus.valid <= next_req_valid;
         csr_bus.valid <= next_csr_valid;
      end
   end

   // Response monitor: check each transaction, then pick the next ready value
   always @(posedge clock) begin : rsp_monitor
      verdict_type due;
      int unsigned r;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         calm_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdicts_due.size() == 0) begin
               $error("unexpected response: cookie %h accepted %b",
                      rsp_bus.cookie, rsp_bus.accepted);
               error_count++;
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_bus.cookie !== due.cookie) begin
                  $error("cookie mismatch: expected %h, actual %h", due.cookie, rsp_bus.cookie);
                  error_count++;
               end
               if (rsp_bus.accepted !== due.accepted) begin
                  $error("accepted mismatch: expected %b, actual %b",
                         due.accepted, rsp_bus.accepted);
                  error_count++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
         end else if (calm_left != 0) begin
            calm_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 6)
               calm_left = $urandom_range(20, 120);
            else if (r < 35)
               stall_left = pick_gap();
         end
         rsp_bus.ready <= !hold_off && stall_left == 0;
      end
   end

   // Long receiver hold-off while the sender keeps offering; the pipeline backs up
   initial begin : rsp_hold
      hold_off = 1'b0;
      while (req_count < HOLD_AFTER) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : run_limit
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      syn_req_type r;
      int unsigned pick;
      int unsigned wait_cycles;
      word_type    phase_secret[6];

      clock = 1'b0;
      reset = 1'b1;
      error_count = 0;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_GENERATE;
      req_bus.src_addr = '0;
      req_bus.src_tcp_port = '0;
      req_bus.dst_addr = '0;
      req_bus.dst_tcp_port = '0;
      req_bus.tick_now = '0;
      req_bus.ack_number = '0;
      csr_bus.valid = 1'b0;
      csr_bus.hash_secret = '0;
      rsp_bus.ready = 1'b0;
      plan_secret = '0;

      // Directed, secret at its reset value
      push_req(syn_req(REQ_GENERATE, '0, '0, '0, '0, '0, '0));
      push_req(syn_req(REQ_GENERATE, '1, '1, '1, '1, '1, '1));
      push_req(syn_req(REQ_VALIDATE, '0, '0, '0, '0, '0, '0));
      push_req(with_ack(syn_req(REQ_VALIDATE, '1, '1, '1, '1, '1, '0), plan_secret, 0));
      // bucket zero: current bucket matches, previous bucket is never tried
      push_req(with_ack(syn_req(REQ_VALIDATE, 32'hC0A80001, 16'd443, 32'h0A000002,
                                16'd51000, 32'h1F, '0), plan_secret, 0));
      push_req(with_ack(syn_req(REQ_VALIDATE, 32'hC0A80001, 16'd443, 32'h0A000002,
                                16'd51000, 32'h1F, '0), plan_secret, 1));
      push_req(with_ack(syn_req(REQ_VALIDATE, 32'hC0A80001, 16'd443, 32'h0A000002,
                                16'd51000, 32'h20, '0), plan_secret, 1));
      push_req(with_ack(syn_req(REQ_VALIDATE, 32'h12345678, 16'd80, 32'h9ABCDEF0,
                                16'd1024, 32'h00ABCDEF, '0), plan_secret, 2));
      r = with_ack(syn_req(REQ_VALIDATE, 32'h7F000001, 16'd22, 32'h7F000001,
                           16'd22, 32'h5555AAAA, '0), plan_secret, 0);
      r.ack = r.ack + 32'd1;
      push_req(r);
      // generate ignores an ack that would have matched
      push_req(with_ack(syn_req(REQ_GENERATE, 32'h01020304, 16'd1, 32'h05060708,
                                16'd2, 32'h00001000, '0), plan_secret, 0));
      push_req(with_ack(syn_req(REQ_VALIDATE, 32'hAAAAAAAA, 16'hFFFF, 32'h55555555,
                                16'h0000, 32'h80000000, '0), plan_secret, 1));
      push_req(syn_req(REQ_GENERATE, 32'h55555555, 16'h0000, 32'hAAAAAAAA, 16'hFFFF,
                       32'h7FFFFFFF, 32'h80000000));
      push_req(with_ack(syn_req(REQ_VALIDATE, 32'hDEADBEEF, 16'd8080, 32'hCAFEF00D,
                                16'd65000, '1, '0), plan_secret, 1));

      push_secret('1);
      push_req(syn_req(REQ_GENERATE, '0, '0, '0, '0, '0, '0));
      push_req(with_ack(syn_req(REQ_VALIDATE, '1, '1, '1, '1, '1, '0), plan_secret, 0));
      push_req(with_ack(syn_req(REQ_VALIDATE, 32'h0A0B0C0D, 16'd5000, 32'h11223344,
                                16'd6000, 32'h00000040, '0), plan_secret, 1));
      push_req(with_ack(syn_req(REQ_VALIDATE, 32'h0A0B0C0D, 16'd5000, 32'h11223344,
                                16'd6000, 32'h00000005, '0), plan_secret, 1));
      push_req(syn_req(REQ_VALIDATE, 32'h31415926, 16'd123, 32'h27182818, 16'd321,
                       32'h00C0FFEE, 32'h0BADF00D));

      phase_secret[0] = $urandom();
      phase_secret[1] = 32'h00000001;
      phase_secret[2] = $urandom();
      phase_secret[3] = 32'h00000000;
      phase_secret[4] = $urandom();
      phase_secret[5] = 32'hFFFFFFFF;

      foreach (phase_secret[p]) begin
         push_secret(phase_secret[p]);
         for (int i = 0; i < 172; i++) begin
            r = syn_req($urandom_range(0, 1) ? REQ_VALIDATE : REQ_GENERATE,
                        $urandom(), port_type'($urandom_range(0, 65535)), $urandom(),
                        port_type'($urandom_range(0, 65535)), $urandom(), $urandom());
            pick = $urandom_range(0, 19);
            if (pick == 0)
               r.saddr = '0;
            else if (pick == 1)
               r.saddr = '1;
            else if (pick == 2)
               r.daddr = '0;
            else if (pick == 3)
               r.daddr = '1;
            // low ticks reach buckets zero, one and two
            if ($urandom_range(0, 99) < 20)
               r.tick = $urandom_range(0, 95);
            if (r.kind == REQ_VALIDATE) begin
               pick = $urandom_range(0, 99);
               if (pick < 40)
                  r = with_ack(r, plan_secret, 0);
               else if (pick < 70)
                  r = with_ack(r, plan_secret, 1);
               else if (pick < 80)
                  r = with_ack(r, plan_secret, 2);
            end
            r.no_gap = ((i / 32) % 4) == 2;
            push_req(r);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_live || csr_live) @(posedge clock);
      for (wait_cycles = 0; wait_cycles < 4000 && verdicts_due.size() != 0; wait_cycles++)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (verdicts_due.size() != 0) begin
         $error("%0d responses never arrived", verdicts_due.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
